// ----- hdl/mvrms_pkg.sv -----
package mvrms_pkg;

  localparam int DATA_WIDTH       = 16;
  localparam int MAX_CHANNELS_DEF = 64;
  localparam int CH_W             = 6;
  localparam int COMP_W           = 4;
  localparam int SUM_W            = 40;
  localparam int SCALE_W          = 24;
  localparam int RECIP_W          = 17;
  localparam int EPS_W            = 33;
  localparam int CIU_W            = 7;
  localparam int M_W              = 41;
  localparam int Q_W              = 57;
  localparam int CNT_W            = 6;
  localparam int DIV_STEPS        = 56;
  localparam int SQRT_STEPS       = 28;
  localparam int PADDR_W          = 5;
  localparam int PDATA_W          = 64;

  localparam logic [1:0] REG_CHANNELS = 2'd0;
  localparam logic [1:0] REG_RECIP    = 2'd1;
  localparam logic [1:0] REG_EPS      = 2'd2;
  localparam logic [1:0] REG_WEIGHT   = 2'd3;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_MEAN_LO,
    S_MEAN_HI,
    S_MAX,
    S_DIV,
    S_SQRT,
    S_FIN,
    S_RD_MEM,
    S_RD_MUL,
    S_RD_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic sum_add;
    logic mean_lo;
    logic mean_hi;
    logic take_max;
    logic div_step;
    logic sqrt_step;
    logic finish;
    logic rd_mul1;
    logic rd_mul2;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic last;
    logic out_free;
  } status_t;

  function automatic logic summed_comp(input logic [COMP_W-1:0] c);
    case (c)
      4'd0, 4'd2, 4'd3, 4'd4, 4'd8, 4'd9, 4'd10, 4'd14: summed_comp = 1'b1;
      default: summed_comp = 1'b0;
    endcase
  endfunction

endpackage

// ----- hdl/mvrms_ram.sv -----
module mvrms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/mvrms_ctrl.sv -----
module mvrms_ctrl
  import mvrms_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_action,
  input  status_t status,
  output logic    in_ready,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_action == ACT_READ) ? S_RD_MEM : S_LOAD;
        end
      end
      S_LOAD:    state_nxt = status.last ? S_MEAN_LO : S_IDLE;
      S_MEAN_LO: state_nxt = S_MEAN_HI;
      S_MEAN_HI: state_nxt = S_MAX;
      S_MAX:     state_nxt = S_DIV;
      S_DIV:     state_nxt = status.cnt_zero ? S_SQRT : S_DIV;
      S_SQRT:    state_nxt = status.cnt_zero ? S_FIN : S_SQRT;
      S_FIN:     state_nxt = S_IDLE;
      S_RD_MEM:  state_nxt = S_RD_MUL;
      S_RD_MUL:  state_nxt = S_RD_OUT;
      S_RD_OUT:  state_nxt = status.out_free ? S_IDLE : S_RD_OUT;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_LOAD:    cmd.sum_add   = 1'b1;
      S_MEAN_LO: cmd.mean_lo   = 1'b1;
      S_MEAN_HI: cmd.mean_hi   = 1'b1;
      S_MAX:     cmd.take_max  = 1'b1;
      S_DIV:     cmd.div_step  = 1'b1;
      S_SQRT:    cmd.sqrt_step = 1'b1;
      S_FIN:     cmd.finish    = 1'b1;
      S_RD_MEM:  cmd.rd_mul1   = 1'b1;
      S_RD_MUL:  cmd.rd_mul2   = 1'b1;
      S_RD_OUT:  cmd.out_load  = status.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

// ----- hdl/mvrms_dp.sv -----
module mvrms_dp
  import mvrms_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cmd_t                         cmd,
  output status_t                      status,
  input  logic [CH_W-1:0]              in_channel,
  input  logic [COMP_W-1:0]            in_component,
  input  logic signed [DATA_WIDTH-1:0] in_sample_value,
  input  logic signed [DATA_WIDTH-1:0] in_channel_weight,
  input  logic                         in_action,
  input  logic                         in_last_of_set,
  input  logic [CIU_W-1:0]             channels_in_use,
  input  logic [RECIP_W-1:0]           recip_channels,
  input  logic [EPS_W-1:0]             eps_floor,
  input  logic                         use_weight,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_value,
  output logic                         out_scale_ready
);

  localparam int CH_AW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CH_DEP  = 1 << CH_AW;
  localparam int CMP_DEP = CH_DEP * 16;
  localparam int LIMIT_W = 11;
  localparam logic [SCALE_W-1:0] SCALE_MAX = '1;
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic signed [Q_W-1:0] HI_LIM = Q_W'((1 << (DATA_WIDTH - 1)) - 1);
  localparam logic signed [Q_W-1:0] LO_LIM = -HI_LIM - Q_W'(1);

  // front end
  logic                     ok_in;
  logic                     ok_r;
  logic                     last_r;
  logic                     sum_en_r;
  logic [CH_AW+3:0]         caddr;
  logic [CH_AW-1:0]         waddr;
  logic signed [31:0]       sq;
  logic [31:0]              sq_r;
  logic signed [DATA_WIDTH-1:0] comp_rdata;
  logic signed [DATA_WIDTH-1:0] w_rdata;

  // scale path
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [SUM_W:0]     sum_add;
  logic [36:0]        lo_r, hi_r;
  logic [Q_W-1:0]     full;
  logic [M_W-1:0]     mean;
  logic [M_W-1:0]     m_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [M_W-1:0]     rem_r;
  logic [M_W:0]       rem_sh;
  logic               ge;
  logic [Q_W-1:0]     q_r;
  logic [Q_W-1:0]     v_r;
  logic [Q_W-1:0]     root_r;
  logic [Q_W-1:0]     sbit;
  logic [Q_W-1:0]     trial;
  logic [SCALE_W-1:0] scale_r;
  logic               scale_valid_r;

  // readout path
  logic signed [40:0]           prod1_r;
  logic signed [Q_W-1:0]        p2;
  logic signed [Q_W-1:0]        shv;
  logic signed [DATA_WIDTH-1:0] sat;
  logic signed [DATA_WIDTH-1:0] res_r;
  logic                         res_sr_r;
  logic signed [DATA_WIDTH-1:0] out_value_r;
  logic                         out_sr_r;
  logic                         out_valid_r;

  assign ok_in = (LIMIT_W'(in_channel) < LIMIT_W'(channels_in_use)) &&
                 (LIMIT_W'(in_channel) < LIMIT_W'(MAX_CHANNELS));
  assign waddr = CH_AW'(in_channel);
  assign caddr = {waddr, in_component};
  assign sq    = in_sample_value * in_sample_value;

  mvrms_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CMP_DEP)) u_comp_ram (
    .clk   (clk),
    .we    (cmd.accept && in_action == ACT_LOAD && ok_in),
    .waddr (caddr),
    .wdata (in_sample_value),
    .re    (cmd.accept && in_action == ACT_READ),
    .raddr (caddr),
    .rdata (comp_rdata)
  );

  mvrms_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CH_DEP)) u_weight_ram (
    .clk   (clk),
    .we    (cmd.accept && in_action == ACT_LOAD && ok_in && in_component == '0),
    .waddr (waddr),
    .wdata (in_channel_weight),
    .re    (cmd.accept && in_action == ACT_READ),
    .raddr (waddr),
    .rdata (w_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ok_r     <= ok_in;
      last_r   <= in_last_of_set;
      sum_en_r <= ok_in && summed_comp(in_component);
      sq_r     <= 32'(sq);
    end
  end

  // saturating square sum
  assign sum_add = {1'b0, sum_r} + (SUM_W + 1)'(sq_r);
  always_comb begin
    sum_nxt = sum_r;
    if (cmd.sum_add && sum_en_r) begin
      sum_nxt = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
    end else if (cmd.finish) begin
      sum_nxt = '0;
    end
  end

  // mean = sum * recip >> 16, product split in two 20-bit halves
  assign full = {hi_r, 20'b0} + Q_W'(lo_r);
  assign mean = M_W'(full >> 16);

  // long division of 2^56 by m, one quotient bit per cycle
  assign rem_sh = {rem_r, (cnt_r == CNT_W'(DIV_STEPS))};
  assign ge     = rem_sh >= {1'b0, m_r};

  // digit-by-digit square root, one result bit per cycle
  assign sbit  = Q_W'(1) << {cnt_r, 1'b0};
  assign trial = root_r + sbit;

  always_ff @(posedge clk) begin
    if (cmd.mean_lo) lo_r <= sum_r[19:0] * recip_channels;
    if (cmd.mean_hi) hi_r <= sum_r[39:20] * recip_channels;
    if (cmd.take_max) begin
      m_r   <= (mean > M_W'(eps_floor)) ? mean : M_W'(eps_floor);
      rem_r <= '0;
      q_r   <= '0;
      cnt_r <= CNT_W'(DIV_STEPS);
    end
    if (cmd.div_step) begin
      rem_r <= ge ? M_W'(rem_sh - {1'b0, m_r}) : rem_sh[M_W-1:0];
      q_r   <= {q_r[Q_W-2:0], ge};
      if (cnt_r == '0) begin
        v_r    <= {q_r[Q_W-2:0], ge};
        root_r <= '0;
        cnt_r  <= CNT_W'(SQRT_STEPS);
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
    if (cmd.sqrt_step) begin
      if (v_r >= trial) begin
        v_r    <= v_r - trial;
        root_r <= (root_r >> 1) + sbit;
      end else begin
        root_r <= root_r >> 1;
      end
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r         <= '0;
      scale_r       <= '0;
      scale_valid_r <= 1'b0;
    end else begin
      sum_r <= sum_nxt;
      if (cmd.finish) begin
        scale_valid_r <= 1'b1;
        if (m_r == '0 || root_r > Q_W'(SCALE_MAX)) begin
          scale_r <= SCALE_MAX;
        end else begin
          scale_r <= SCALE_W'(root_r);
        end
      end
    end
  end

  // readout: x * scale, then * w if use_weight is set, floor shift, saturate
  assign p2  = prod1_r * w_rdata;
  assign shv = use_weight ? (p2 >>> 29) : (Q_W'(prod1_r) >>> 16);
  always_comb begin
    if (shv > HI_LIM) begin
      sat = DATA_WIDTH'(HI_LIM);
    end else if (shv < LO_LIM) begin
      sat = DATA_WIDTH'(LO_LIM);
    end else begin
      sat = DATA_WIDTH'(shv);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_mul1) prod1_r <= comp_rdata * $signed({1'b0, scale_r});
    if (cmd.rd_mul2) begin
      res_r    <= ok_r ? sat : '0;
      res_sr_r <= scale_valid_r;
    end
    if (cmd.out_load) begin
      out_value_r <= res_r;
      out_sr_r    <= res_sr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.cnt_zero = (cnt_r == '0);
  assign status.last     = last_r;
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_scale_ready = out_sr_r;

endmodule

// ----- hdl/multivector_rms_norm_core.sv -----
// RMS normalizer for one set of 16-component multivector channels. A load word
// (action 0) stores a Q3.12 component, with the channel's Q2.13 weight on
// component 0, and adds its square to the sum for components 0,2,3,4,8,9,10,14.
// A load marked last_of_set then computes, with a bit-serial divider and a
// bit-serial square root, the Q8.16 scale 1/sqrt(max(sum*recip_channels,
// eps_floor)), during which no word is taken. A readout word (action 1)
// goes through the component/weight memory read and two multiplies; the result
// sits in an output register so the next word can be taken while it waits.
// Out of range channels are not stored and read out as 0. Registers sit at
// byte addresses 0, 8, 16, 24 of the 64-bit config port.
module multivector_rms_norm_core
  import mvrms_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_action,
  input  logic [CH_W-1:0]              in_channel,
  input  logic [COMP_W-1:0]            in_component,
  input  logic signed [DATA_WIDTH-1:0] in_sample_value,
  input  logic signed [DATA_WIDTH-1:0] in_channel_weight,
  input  logic                         in_last_of_set,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_value,
  output logic                         out_scale_ready,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [PADDR_W-1:0]           paddr,
  input  logic [PDATA_W-1:0]           pwdata,
  output logic [PDATA_W-1:0]           prdata,
  output logic                         pready
);

  logic [CIU_W-1:0]   channels_in_use_r;
  logic [RECIP_W-1:0] recip_channels_r;
  logic [EPS_W-1:0]   eps_floor_r;
  logic               use_weight_r;
  logic [1:0]         reg_idx;
  cmd_t               cmd;
  status_t            status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channels_in_use_r <= CIU_W'(64);
      recip_channels_r  <= RECIP_W'(1024);
      eps_floor_r       <= EPS_W'(1);
      use_weight_r      <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_CHANNELS: channels_in_use_r <= pwdata[CIU_W-1:0];
        REG_RECIP:    recip_channels_r  <= pwdata[RECIP_W-1:0];
        REG_EPS:      eps_floor_r       <= pwdata[EPS_W-1:0];
        REG_WEIGHT:   use_weight_r      <= pwdata[0];
        default:      use_weight_r      <= use_weight_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CHANNELS: prdata = PDATA_W'(channels_in_use_r);
      REG_RECIP:    prdata = PDATA_W'(recip_channels_r);
      REG_EPS:      prdata = PDATA_W'(eps_floor_r);
      REG_WEIGHT:   prdata = PDATA_W'(use_weight_r);
      default:      prdata = '0;
    endcase
  end

  mvrms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .status    (status),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  mvrms_dp #(.MAX_CHANNELS(MAX_CHANNELS)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_channel        (in_channel),
    .in_component      (in_component),
    .in_sample_value   (in_sample_value),
    .in_channel_weight (in_channel_weight),
    .in_action         (in_action),
    .in_last_of_set    (in_last_of_set),
    .channels_in_use   (channels_in_use_r),
    .recip_channels    (recip_channels_r),
    .eps_floor         (eps_floor_r),
    .use_weight        (use_weight_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_value         (out_value),
    .out_scale_ready   (out_scale_ready)
  );

endmodule

// ----- tb/sv/tb_multivector_rms_norm_core.sv -----
`timescale 1ns / 100ps

module tb_multivector_rms_norm_core;
  import mvrms_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 150;
  localparam logic [SUM_W-1:0] SUM_SAT = {SUM_W{1'b1}};
  localparam logic [SCALE_W-1:0] SCALE_SAT = {SCALE_W{1'b1}};

  typedef struct {
    logic                         action;
    logic [CH_W-1:0]              ch;
    logic [COMP_W-1:0]            comp;
    logic signed [DATA_WIDTH-1:0] val;
    logic signed [DATA_WIDTH-1:0] wt;
    logic                         last;
  } word_t;

  typedef struct {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         ready;
  } norm_out_t;

  typedef struct {
    word_t                        w;
    bit                           typed;
    logic signed [DATA_WIDTH-1:0] value;
    logic                         ready;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_action = ACT_LOAD;
  logic [CH_W-1:0] in_channel = '0;
  logic [COMP_W-1:0] in_component = '0;
  logic signed [DATA_WIDTH-1:0] in_sample_value = '0;
  logic signed [DATA_WIDTH-1:0] in_channel_weight = '0;
  logic in_last_of_set = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_WIDTH-1:0] out_value;
  logic out_scale_ready;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  multivector_rms_norm_core dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic signed [DATA_WIDTH-1:0] comp_mem [64][16];
  logic signed [DATA_WIDTH-1:0] wt_mem [64];
  bit comp_seen [64][16];
  bit wt_seen [64];
  logic [SUM_W-1:0] sq_sum;
  logic [SCALE_W-1:0] scale;
  logic scale_ok;
  logic [CIU_W-1:0] ciu;
  logic [RECIP_W-1:0] recip;
  logic [EPS_W-1:0] eps;
  logic use_wt;

  norm_out_t pending[$];
  int errors = 0;
  int n_loads = 0, n_reads = 0, n_sets = 0, n_checked = 0, n_phases = 0;
  bit burst = 0;
  int idle_cycles = 0;

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d (t=%0t)", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void finish_set();
    logic [63:0] mean, m, s;
    mean = ({24'd0, sq_sum} * {47'd0, recip}) >> 16;
    m = (mean > {31'd0, eps}) ? mean : {31'd0, eps};
    if (m == 0) begin
      s = {40'd0, SCALE_SAT};
    end else begin
      s = int_sqrt((64'd1 << 56) / m);
      if (s > {40'd0, SCALE_SAT}) s = {40'd0, SCALE_SAT};
    end
    scale = s[SCALE_W-1:0];
    scale_ok = 1'b1;
    sq_sum = '0;
    n_sets++;
  endfunction

  // updates state for an accepted word; returns 1 with the expected result for a readout
  function automatic bit norm_predict(word_t w, output norm_out_t o);
    bit in_range;
    longint p, r, sq;
    logic [63:0] t;
    in_range = w.ch < ciu;
    o.value = '0;
    o.ready = 1'b0;
    if (w.action == ACT_LOAD) begin
      if (in_range) begin
        comp_mem[w.ch][w.comp] = w.val;
        comp_seen[w.ch][w.comp] = 1;
        if (w.comp == 0) begin
          wt_mem[w.ch] = w.wt;
          wt_seen[w.ch] = 1;
        end
        if (summed_comp(w.comp)) begin
          sq = longint'(w.val) * longint'(w.val);
          t = {24'd0, sq_sum} + 64'(sq);
          sq_sum = (t > {24'd0, SUM_SAT}) ? SUM_SAT : t[SUM_W-1:0];
        end
      end
      if (w.last) finish_set();
      return 0;
    end
    r = 0;
    if (in_range) begin
      p = longint'(comp_mem[w.ch][w.comp]) * longint'({1'b0, scale});
      if (use_wt) r = (p * longint'(wt_mem[w.ch])) >>> 29;
      else r = p >>> 16;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
    end
    o.value = r[DATA_WIDTH-1:0];
    o.ready = scale_ok;
    return 1;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (burst || k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one word through the input channel; typed rows carry their own expectation
  task automatic send_word(word_t w, bit typed = 0, norm_out_t te = '{0, 0});
    int g;
    norm_out_t o;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_action <= w.action;
    in_channel <= w.ch;
    in_component <= w.comp;
    in_sample_value <= w.val;
    in_channel_weight <= w.wt;
    in_last_of_set <= w.last;
    in_valid <= 1'b1;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    if (norm_predict(w, o)) begin
      pending.push_back(typed ? te : o);
      n_reads++;
    end else begin
      n_loads++;
    end
    @(negedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [PDATA_W-1:0] d);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 3'b000};
    pwdata <= d;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CHANNELS: ciu = d[CIU_W-1:0];
      REG_RECIP:    recip = d[RECIP_W-1:0];
      REG_EPS:      eps = d[EPS_W-1:0];
      REG_WEIGHT:   use_wt = d[0];
      default:      use_wt = use_wt;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic signed [DATA_WIDTH-1:0] pick_val();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return DATA_WIDTH'($signed($urandom_range(0, 511)) - 256);
      default: return DATA_WIDTH'($urandom);
    endcase
  endfunction

  task automatic run_phase(int quota);
    int cnt, nch, k, tries;
    word_t w;
    cnt = 0;
    while (cnt < quota) begin
      if ($urandom_range(0, 9) < 7) begin
        nch = $urandom_range(1, (ciu < 6) ? ciu : 6);
        for (int c = 0; c < nch; c++) begin
          for (int m = 0; m < 16; m++) begin
            w.action = ACT_LOAD;
            w.ch = c;
            w.comp = m;
            w.val = pick_val();
            w.wt = pick_val();
            w.last = (c == nch - 1) && (m == 15);
            send_word(w);
            cnt++;
          end
        end
        k = $urandom_range(2, 12);
        for (int i = 0; i < k; i++) begin
          w.action = ACT_READ;
          w.last = $urandom_range(0, 1);
          tries = 0;
          do begin
            w.ch = $urandom_range(0, 63);
            w.comp = $urandom_range(0, 15);
            tries++;
          end while (w.ch < ciu && !(comp_seen[w.ch][w.comp] && wt_seen[w.ch]) && tries < 64);
          if (w.ch < ciu && !(comp_seen[w.ch][w.comp] && wt_seen[w.ch])) begin
            w.ch = 0;
            w.comp = 0;
          end
          send_word(w);
          cnt++;
        end
      end else begin
        w.action = $urandom_range(0, 1);
        w.ch = $urandom_range(0, 63);
        w.comp = $urandom_range(0, 15);
        w.val = DATA_WIDTH'($urandom);
        w.wt = DATA_WIDTH'($urandom);
        w.last = ($urandom_range(0, 7) == 0);
        if (w.action == ACT_READ && w.ch < ciu && !(comp_seen[w.ch][w.comp] && wt_seen[w.ch]))
          w.action = ACT_LOAD;
        send_word(w);
        cnt++;
      end
      burst = ($urandom_range(0, 19) == 0) ? !burst : burst;
    end
    drain();
  endtask

  // result side: random back-pressure
  int stall = 0;
  always @(negedge clk) begin
    if (stall > 0) begin
      out_ready <= 1'b0;
      stall <= stall - 1;
    end else begin
      out_ready <= 1'b1;
      if (!burst && $urandom_range(0, 9) < 3)
        stall <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    end
  end

  always @(posedge clk) begin
    norm_out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        $display("unexpected word out: value %0d (t=%0t)", out_value, $realtime);
        errors++;
      end else begin
        e = pending.pop_front();
        n_checked++;
        if (out_value !== e.value) report_mismatch("out_value", out_value, e.value);
        if (out_scale_ready !== e.ready)
          report_mismatch("out_scale_ready", out_scale_ready, e.ready);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("FAIL multivector_rms_norm_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  dir_row_t dir_rows[] = '{
    '{'{ACT_LOAD, 6'd0, 4'd0, 16'sh7fff, 16'sd8192, 1'b0}, 0, 16'sd0, 1'b0},
    // no scale yet: readout gives zero
    '{'{ACT_READ, 6'd0, 4'd0, 16'sd0, 16'sd0, 1'b0}, 1, 16'sd0, 1'b0},
    '{'{ACT_LOAD, 6'd0, 4'd1, 16'sh8000, 16'sd0, 1'b0}, 0, 16'sd0, 1'b0},
    '{'{ACT_LOAD, 6'd0, 4'd2, 16'sh8000, 16'sd0, 1'b0}, 0, 16'sd0, 1'b0},
    '{'{ACT_LOAD, 6'd0, 4'd2, 16'sh8000, 16'sd0, 1'b0}, 0, 16'sd0, 1'b0},
    '{'{ACT_LOAD, 6'd0, 4'd15, 16'sd0, 16'sd0, 1'b0}, 0, 16'sd0, 1'b0},
    '{'{ACT_LOAD, 6'd63, 4'd0, 16'sd1, 16'sh8000, 1'b0}, 0, 16'sd0, 1'b0},
    '{'{ACT_LOAD, 6'd63, 4'd14, 16'shffff, 16'sh7fff, 1'b1}, 0, 16'sd0, 1'b0},
    '{'{ACT_READ, 6'd0, 4'd0, 16'sd0, 16'sd0, 1'b0}, 0, 16'sd0, 1'b0},
    '{'{ACT_READ, 6'd0, 4'd1, 16'sd0, 16'sd0, 1'b1}, 0, 16'sd0, 1'b0},
    '{'{ACT_READ, 6'd0, 4'd15, 16'sd0, 16'sd0, 1'b0}, 0, 16'sd0, 1'b0},
    '{'{ACT_READ, 6'd63, 4'd0, 16'sd0, 16'sd0, 1'b0}, 0, 16'sd0, 1'b0},
    '{'{ACT_READ, 6'd63, 4'd14, 16'sd0, 16'sd0, 1'b0}, 0, 16'sd0, 1'b0},
    '{'{ACT_LOAD, 6'd1, 4'd0, 16'sd3, 16'sd8192, 1'b0}, 0, 16'sd0, 1'b0},
    '{'{ACT_LOAD, 6'd1, 4'd5, 16'sd100, 16'sd0, 1'b1}, 0, 16'sd0, 1'b0},
    '{'{ACT_READ, 6'd1, 4'd0, 16'sd0, 16'sd0, 1'b0}, 0, 16'sd0, 1'b0},
    '{'{ACT_READ, 6'd1, 4'd5, 16'sd0, 16'sd0, 1'b0}, 0, 16'sd0, 1'b0}
  };

  initial begin
    norm_out_t te;
    sq_sum = '0;
    scale = '0;
    scale_ok = 1'b0;
    ciu = 7'd64;
    recip = 17'd1024;
    eps = 33'd1;
    use_wt = 1'b1;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      te.value = dir_rows[i].value;
      te.ready = dir_rows[i].ready;
      send_word(dir_rows[i].w, dir_rows[i].typed, te);
    end
    drain();

    // settings per phase: channels, reciprocal, floor, weighting
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          reg_write(REG_CHANNELS, 64'd1);
          reg_write(REG_RECIP, 64'd65536);
          reg_write(REG_EPS, 64'd1);
          reg_write(REG_WEIGHT, 64'd0);
        end
        1: begin
          reg_write(REG_CHANNELS, 64'd64);
          reg_write(REG_RECIP, 64'd1);
          reg_write(REG_EPS, 64'h1_ffff_ffff);
          reg_write(REG_WEIGHT, 64'd1);
        end
        2: begin
          reg_write(REG_CHANNELS, 64'd4);
          reg_write(REG_RECIP, 64'd16384);
          reg_write(REG_EPS, 64'd1 << 20);
          reg_write(REG_WEIGHT, 64'd1);
        end
        default: begin
          reg_write(REG_CHANNELS, 64'($urandom_range(1, 8)));
          reg_write(REG_RECIP, 64'($urandom_range(1, 65536)));
          reg_write(REG_EPS, {31'd0, 1'($urandom), $urandom} | 64'd1);
          reg_write(REG_WEIGHT, 64'($urandom_range(0, 1)));
        end
      endcase
      n_phases++;
      run_phase(330);
    end

    repeat (20) @(negedge clk);
    $display("covered %0d loads, %0d readouts (%0d checked), %0d scale computations",
             n_loads, n_reads, n_checked, n_sets);
    $display("across %0d register settings plus the reset setting", n_phases);
    if (errors == 0 && pending.size() == 0) begin
      $display("PASS multivector_rms_norm_core");
    end else begin
      $display("FAIL multivector_rms_norm_core");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/mvrms_pkg.sv
hdl/mvrms_ram.sv
hdl/mvrms_ctrl.sv
hdl/mvrms_dp.sv
hdl/multivector_rms_norm_core.sv
tb/sv/tb_multivector_rms_norm_core.sv
